// ===== design/plk_pkg.sv =====
// Shared operation codes, status codes and field widths of the positional list engine.
package plk_pkg;

    localparam int OP_W    = 2;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int LEN_W   = 5;
    localparam int STAT_W  = 2;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_op OP_INSERT  = 2'd0;
    localparam t_op OP_REMOVE  = 2'd1;
    localparam t_op OP_REVERSE = 2'd2;
    localparam t_op OP_DUMP    = 2'd3;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BADPOS = 2'd1;
    localparam t_status ST_FULL   = 2'd2;
    localparam t_status ST_EMPTY  = 2'd3;

endpackage

// ===== design/positional_list_engine_top.sv =====
// Positional list engine: ordered list of signed values held in one synchronous memory.
//
// A request is taken at a rising edge where start is high and busy is low. It
// carries an operation (insert, remove, reverse, dump), a value and a 1-based
// position. Every request answers with one result, except a dump of a
// non-empty list, which answers with one result per entry in list order. Each
// result is shown for exactly one cycle with o_result_valid high, and
// o_last_result marks the final result of a request. The receiver cannot
// stall the block, so results are never held back.
// Work is paced by the one-read one-write memory, whose read data is registered:
// insert moves entries back one at a time, remove moves them forward, reverse
// swaps pairs from the outside in, and dump reads and sends each entry in turn.
// Busy is low by the time the final result of a request is shown.
// Reset clears the entry count, the sequencer state and the result valid flag; the memory
// contents are not cleared, since only entries below the count are ever read.
module positional_list_engine_top
    import plk_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         i_operation,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_result_valid,
    output logic signed [VAL_W-1:0] o_entry_value,
    output logic [STAT_W-1:0]       o_status,
    output logic [LEN_W-1:0]        o_list_length,
    output logic                    o_last_result
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_WR  = 4'd2;
    localparam logic [3:0] S_DEL_RD  = 4'd3;
    localparam logic [3:0] S_DEL_WR  = 4'd4;
    localparam logic [3:0] S_REV_RDL = 4'd5;
    localparam logic [3:0] S_REV_RDH = 4'd6;
    localparam logic [3:0] S_REV_WRL = 4'd7;
    localparam logic [3:0] S_REV_WRH = 4'd8;
    localparam logic [3:0] S_DMP_RD  = 4'd9;
    localparam logic [3:0] S_DMP_OUT = 4'd10;

    // Control state
    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_tgt, n_tgt;
    logic [AW-1:0]    r_lo, n_lo;
    logic [AW-1:0]    r_hi, n_hi;
    logic [VAL_W-1:0] r_val, n_val;
    logic [VAL_W-1:0] r_tmp, n_tmp;

    // Result register
    logic              r_res_valid, n_res_valid;
    logic [VAL_W-1:0]  r_res_entry, n_res_entry;
    t_status           r_res_status, n_res_status;
    logic [LEN_W-1:0]  r_res_len, n_res_len;
    logic              r_res_last, n_res_last;

    // Memory ports
    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rd_data;
    logic             mem_re, mem_we;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [VAL_W-1:0] wr_data;

    logic             accept;
    logic [CMPW-1:0]  pos_ext, cnt_ext;
    logic [CW:0]      idx_inc;
    logic [POS_W-1:0] pos_m1;

    assign accept  = start && (r_state == S_IDLE);
    assign busy    = (r_state != S_IDLE);
    assign pos_ext = CMPW'(i_position);
    assign cnt_ext = CMPW'(r_count);
    assign idx_inc = {1'b0, r_idx} + 1'b1;
    assign pos_m1  = i_position - 1'b1;

    // Sequencer: decodes requests and walks the memory one entry at a time.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_tgt        = r_tgt;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_val        = r_val;
        n_tmp        = r_tmp;
        n_res_valid  = 1'b0;
        n_res_entry  = '0;
        n_res_status = ST_OK;
        n_res_last   = 1'b1;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        rd_addr      = r_idx[AW-1:0];
        wr_addr      = r_idx[AW-1:0];
        wr_data      = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val = i_item_value;
                    n_tgt = CW'(pos_m1);
                    case (i_operation)
                        OP_INSERT: begin
                            if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
                                n_res_valid  = 1'b1;
                                n_res_status = ST_BADPOS;
                            end else if (cnt_ext >= CMPW'(CAPACITY)) begin
                                n_res_valid  = 1'b1;
                                n_res_status = ST_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_ext == '0 || pos_ext > cnt_ext) begin
                                n_res_valid  = 1'b1;
                                n_res_status = ST_BADPOS;
                            end else begin
                                n_idx   = CW'(pos_m1);
                                n_state = S_DEL_RD;
                            end
                        end
                        OP_REVERSE: begin
                            if (r_count > CW'(1)) begin
                                n_lo    = '0;
                                n_hi    = AW'(r_count - 1'b1);
                                n_state = S_REV_RDL;
                            end else begin
                                n_res_valid = 1'b1;
                            end
                        end
                        OP_DUMP: begin
                            if (r_count == '0) begin
                                n_res_valid  = 1'b1;
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_DMP_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            // Insert: move entries back from the tail, then place the value.
            S_INS_RD: begin
                if (r_idx > r_tgt) begin
                    mem_re  = 1'b1;
                    rd_addr = AW'(r_idx - 1'b1);
                    n_state = S_INS_WR;
                end else begin
                    mem_we      = 1'b1;
                    wr_addr     = r_tgt[AW-1:0];
                    wr_data     = r_val;
                    n_count     = r_count + 1'b1;
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_INS_WR: begin
                mem_we  = 1'b1;
                n_idx   = r_idx - 1'b1;
                n_state = S_INS_RD;
            end
            // Remove: move later entries forward, then shorten the list.
            S_DEL_RD: begin
                if (idx_inc < {1'b0, r_count}) begin
                    mem_re  = 1'b1;
                    rd_addr = AW'(idx_inc);
                    n_state = S_DEL_WR;
                end else begin
                    n_count     = r_count - 1'b1;
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DEL_WR: begin
                mem_we  = 1'b1;
                n_idx   = CW'(idx_inc);
                n_state = S_DEL_RD;
            end
            // Reverse: swap the outer pair and step inward.
            S_REV_RDL: begin
                if (r_lo < r_hi) begin
                    mem_re  = 1'b1;
                    rd_addr = r_lo;
                    n_state = S_REV_RDH;
                end else begin
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_REV_RDH: begin
                mem_re  = 1'b1;
                rd_addr = r_hi;
                n_tmp   = r_rd_data;
                n_state = S_REV_WRL;
            end
            S_REV_WRL: begin
                mem_we  = 1'b1;
                wr_addr = r_lo;
                n_state = S_REV_WRH;
            end
            S_REV_WRH: begin
                mem_we  = 1'b1;
                wr_addr = r_hi;
                wr_data = r_tmp;
                n_lo    = r_lo + 1'b1;
                n_hi    = r_hi - 1'b1;
                n_state = S_REV_RDL;
            end
            // Dump: read each entry and send it on the cycle after.
            S_DMP_RD: begin
                mem_re  = 1'b1;
                n_state = S_DMP_OUT;
            end
            S_DMP_OUT: begin
                n_res_valid = 1'b1;
                n_res_entry = r_rd_data;
                n_res_last  = (idx_inc == {1'b0, r_count});
                n_idx       = CW'(idx_inc);
                n_state     = n_res_last ? S_IDLE : S_DMP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res_len = LEN_W'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    // Working and result payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_tgt        <= n_tgt;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_val        <= n_val;
        r_tmp        <= n_tmp;
        r_res_entry  <= n_res_entry;
        r_res_status <= n_res_status;
        r_res_len    <= n_res_len;
        r_res_last   <= n_res_last;
    end

    // Entry memory with registered read data
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_entry_value  = r_res_entry;
    assign o_status       = r_res_status;
    assign o_list_length  = r_res_len;
    assign o_last_result  = r_res_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= (CW+1)'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted request neither started nor answered");

    a_mid_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last_result) |-> busy)
        else $error("non-final result while engine idle");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE))
        else $error("memory written while idle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_count == $past(r_count) + 1'b1 ||
                               r_count == $past(r_count) - 1'b1))
        else $error("entry count changed by more than one");
`endif

endmodule

// ===== verif/plk_list_checker.sv =====
// List-state checker for the positional list engine: mirrors requests and compares results.
`timescale 1ns / 1ps

module plk_list_checker
    import plk_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [OP_W-1:0]         i_operation,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic [POS_W-1:0]        i_position,
    input  logic                    o_result_valid,
    input  logic signed [VAL_W-1:0] o_entry_value,
    input  logic [STAT_W-1:0]       o_status,
    input  logic [LEN_W-1:0]        o_list_length,
    input  logic                    o_last_result,
    output int                      fail_count,
    output int                      pending_results,
    output int                      list_size
);

    // One result as the block should present it.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } t_answer;

    logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
    int                      shadow_len;
    t_answer                 due_answers [$];
    t_answer                 head_answer;

    // Queue one result; the length field always reflects the list after the request.
    function automatic void post_answer(logic signed [VAL_W-1:0] value, t_status status,
                                        logic last);
        t_answer ans;
        ans.value  = value;
        ans.status = status;
        ans.length = LEN_W'(shadow_len);
        ans.last   = last;
        due_answers.push_back(ans);
    endfunction

    // Apply one accepted request to the mirrored list and queue the results it causes.
    function automatic void apply_request(t_op op, logic signed [VAL_W-1:0] value,
                                          logic [POS_W-1:0] pos);
        int                      p;
        int                      i;
        int                      lo;
        int                      hi;
        logic signed [VAL_W-1:0] tmp;
        p = int'(pos);
        case (op)
            OP_INSERT: begin
                // A bad position is flagged before fullness is considered.
                if (p == 0 || p > shadow_len + 1) begin
                    post_answer('0, ST_BADPOS, 1'b1);
                end else if (shadow_len >= CAPACITY) begin
                    post_answer('0, ST_FULL, 1'b1);
                end else begin
                    for (i = shadow_len; i > p - 1; i--) begin
                        shadow_entries[i] = shadow_entries[i-1];
                    end
                    shadow_entries[p-1] = value;
                    shadow_len++;
                    post_answer('0, ST_OK, 1'b1);
                end
            end
            OP_REMOVE: begin
                if (p == 0 || p > shadow_len) begin
                    post_answer('0, ST_BADPOS, 1'b1);
                end else begin
                    for (i = p - 1; i + 1 < shadow_len; i++) begin
                        shadow_entries[i] = shadow_entries[i+1];
                    end
                    shadow_len--;
                    post_answer('0, ST_OK, 1'b1);
                end
            end
            OP_REVERSE: begin
                lo = 0;
                hi = shadow_len - 1;
                while (lo < hi) begin
                    tmp                = shadow_entries[lo];
                    shadow_entries[lo] = shadow_entries[hi];
                    shadow_entries[hi] = tmp;
                    lo++;
                    hi--;
                end
                post_answer('0, ST_OK, 1'b1);
            end
            default: begin
                // Dump: an empty list answers once, otherwise one result per entry.
                if (shadow_len == 0) begin
                    post_answer('0, ST_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < shadow_len; i++) begin
                        post_answer(shadow_entries[i], ST_OK, i == shadow_len - 1);
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(string what, longint want, longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // Results are compared before a request taken at the same edge is applied,
    // since a request never answers at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_len = 0;
            fail_count = 0;
            due_answers.delete();
        end else begin
            if (o_result_valid) begin
                if (due_answers.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none outstanding, expected none, actual value %0d",
                             $time, o_entry_value);
                end else begin
                    head_answer = due_answers.pop_front();
                    check_field("entry_value", head_answer.value, o_entry_value);
                    check_field("status", head_answer.status, o_status);
                    check_field("list_length", head_answer.length, o_list_length);
                    check_field("last_result", head_answer.last, o_last_result);
                end
            end
            if (start && !busy) begin
                apply_request(t_op'(i_operation), i_item_value, i_position);
            end
        end
        pending_results = due_answers.size();
        list_size       = shadow_len;
    end

endmodule

// ===== verif/testbench.sv =====
// Stimulus and verdict for the positional list engine, with the list-state checker beside it.
`timescale 1ns / 1ps

module testbench;
    import plk_pkg::*;

    localparam int                      CAPACITY = 16;
    localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    t_op                     i_operation = OP_INSERT;
    logic signed [VAL_W-1:0] i_item_value = '0;
    logic [POS_W-1:0]        i_position = '0;
    logic                    o_result_valid;
    logic signed [VAL_W-1:0] o_entry_value;
    logic [STAT_W-1:0]       o_status;
    logic [LEN_W-1:0]        o_list_length;
    logic                    o_last_result;
    int                      fail_count;
    int                      pending_results;
    int                      list_size;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    positional_list_engine_top #(.CAPACITY(CAPACITY)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_item_value   (i_item_value),
        .i_position     (i_position),
        .o_result_valid (o_result_valid),
        .o_entry_value  (o_entry_value),
        .o_status       (o_status),
        .o_list_length  (o_list_length),
        .o_last_result  (o_last_result)
    );

    plk_list_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .o_result_valid  (o_result_valid),
        .o_entry_value   (o_entry_value),
        .o_status        (o_status),
        .o_list_length   (o_list_length),
        .o_last_result   (o_last_result),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .list_size       (list_size)
    );

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input t_op op, input logic signed [VAL_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        start        <= 1'b1;
        i_operation  <= op;
        i_item_value <= value;
        i_position   <= pos;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Lower start for a while; the request fields carry noise the block must ignore.
    task automatic hold_off(input int cycles);
        start        <= 1'b0;
        i_operation  <= t_op'($urandom_range(3));
        i_item_value <= $urandom;
        i_position   <= POS_W'($urandom_range(31));
        repeat (cycles) @(negedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return $urandom_range(1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly positions inside the valid range, sometimes anything the field allows.
    function automatic logic [POS_W-1:0] pick_position(t_op op);
        if ($urandom_range(9) == 0) return POS_W'($urandom_range(31));
        if (op == OP_INSERT) return POS_W'($urandom_range(list_size + 1, 1));
        if (op == OP_REMOVE && list_size > 0) return POS_W'($urandom_range(list_size, 1));
        return POS_W'($urandom_range(31));
    endfunction

    initial begin
        int  n;
        int  r;
        int  mode;
        int  guard;
        t_op op;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list cases, bad positions, extremes of value and position,
        // head and tail inserts, head, middle and tail removes, reverse of one, odd and even lists.
        send_request(OP_DUMP, '0, 5'd0);
        send_request(OP_REMOVE, '0, 5'd1);
        send_request(OP_REVERSE, '0, 5'd0);
        send_request(OP_INSERT, 32'sd5, 5'd0);
        send_request(OP_INSERT, 32'sd5, 5'd2);
        send_request(OP_INSERT, VAL_MAX, 5'd1);
        send_request(OP_REVERSE, '0, 5'd0);
        send_request(OP_INSERT, VAL_MIN, 5'd2);
        send_request(OP_REVERSE, '0, 5'd0);
        send_request(OP_INSERT, '1, 5'd1);
        send_request(OP_INSERT, '0, 5'd31);
        send_request(OP_DUMP, '0, 5'd0);
        send_request(OP_REVERSE, '0, 5'd0);
        send_request(OP_DUMP, '0, 5'd0);
        send_request(OP_REMOVE, '0, 5'd0);
        send_request(OP_REMOVE, '0, 5'd4);
        send_request(OP_REMOVE, '0, 5'd2);
        send_request(OP_REMOVE, '0, 5'd2);
        send_request(OP_REMOVE, '0, 5'd1);
        send_request(OP_DUMP, '0, 5'd0);

        // Random: alternate phases that fill the list to capacity, mix, and drain it.
        for (n = 0; n < 150; n++) begin
            mode = (n / 28) % 3;
            r    = $urandom_range(99);
            if (mode == 0) begin
                op = (r < 80) ? OP_INSERT : (r < 85) ? OP_REMOVE :
                     (r < 93) ? OP_DUMP : OP_REVERSE;
            end else if (mode == 1) begin
                op = (r < 35) ? OP_INSERT : (r < 65) ? OP_REMOVE :
                     (r < 85) ? OP_DUMP : OP_REVERSE;
            end else begin
                op = (r < 15) ? OP_INSERT : (r < 70) ? OP_REMOVE :
                     (r < 85) ? OP_DUMP : OP_REVERSE;
            end
            if (n < 125 && $urandom_range(3) == 0) begin
                hold_off($urandom_range(19, 1));
            end
            send_request(op, pick_value(), pick_position(op));
        end
        start <= 1'b0;

        // Drain outstanding results, then allow the longest request time to pass.
        guard = 0;
        while (pending_results != 0 && guard < 2000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("** positional_list_engine_top: PASSED **");
        end else begin
            $display("** positional_list_engine_top: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #1_000_000;
        $display("** positional_list_engine_top: FAILED **");
        $finish;
    end

endmodule
